@@ sv/vpa_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the partition allocator.
`default_nettype none

package vpa_pkg;

  // Default sizing
  localparam int MAX_SLOTS_DEF = 64;
  localparam int SIZE_BITS_DEF = 24;

  // Fixed field widths
  localparam int CMD_W     = 3;
  localparam int PID_W     = 16;
  localparam int IDX_W     = 6;
  localparam int CNT_OUT_W = 7;
  localparam int FT_W      = 30;
  localparam int ST_W      = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_AW    = 1;
  localparam int CFG_DW    = 6;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOCATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COALESCE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COMPACT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

  // Result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Placement policies
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
  localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_FIT_MODE  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_START_PTR = 1'd1;

  // Owner written into free holes
  localparam logic [PID_W-1:0] OWNER_FREE = 16'hFFFF;

  // Datapath micro-operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH     = 5'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd2;
  localparam logic [OP_W-1:0] OP_APPEND    = 5'd3;
  localparam logic [OP_W-1:0] OP_RD_ISSUE  = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_TAKE   = 5'd5;
  localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd6;
  localparam logic [OP_W-1:0] OP_READ_I    = 5'd7;
  localparam logic [OP_W-1:0] OP_A_EVAL    = 5'd8;
  localparam logic [OP_W-1:0] OP_A_DEC     = 5'd9;
  localparam logic [OP_W-1:0] OP_S_READ    = 5'd10;
  localparam logic [OP_W-1:0] OP_S_WRITE   = 5'd11;
  localparam logic [OP_W-1:0] OP_S_INS     = 5'd12;
  localparam logic [OP_W-1:0] OP_C_EVAL    = 5'd13;
  localparam logic [OP_W-1:0] OP_C_END     = 5'd14;
  localparam logic [OP_W-1:0] OP_P_EVAL    = 5'd15;
  localparam logic [OP_W-1:0] OP_Q_EVAL    = 5'd16;
  localparam logic [OP_W-1:0] OP_Q_END     = 5'd17;
  localparam logic [OP_W-1:0] OP_M_EVAL    = 5'd18;
  localparam logic [OP_W-1:0] OP_FIN       = 5'd19;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;   // scan index reached the entry count
    logic shift_end;  // insert shift reached the slot after the hole
    logic in_range;   // read index below the entry count
    logic dec_fail;   // allocate cannot proceed
    logic dec_split;  // allocate leaves a nonzero remainder and the table has room
    logic any_free;   // compact found a free entry
    logic out_full;   // result register occupied and stalled
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/vpa_ctrl.sv @@
// Sequencer that steps the datapath through each command's table scans.
`default_nettype none

module vpa_ctrl
  import vpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CMD_W-1:0] in_command,
  output dp_cmd_t               cmd,
  input  wire dp_stat_t         stat
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_APP    = 5'd2;
  localparam logic [4:0] S_RDI    = 5'd3;
  localparam logic [4:0] S_RDT    = 5'd4;
  localparam logic [4:0] S_A_INIT = 5'd5;
  localparam logic [4:0] S_A_RD   = 5'd6;
  localparam logic [4:0] S_A_EV   = 5'd7;
  localparam logic [4:0] S_A_DEC  = 5'd8;
  localparam logic [4:0] S_S_RD   = 5'd9;
  localparam logic [4:0] S_S_WR   = 5'd10;
  localparam logic [4:0] S_S_INS  = 5'd11;
  localparam logic [4:0] S_C_INIT = 5'd12;
  localparam logic [4:0] S_C_RD   = 5'd13;
  localparam logic [4:0] S_C_EV   = 5'd14;
  localparam logic [4:0] S_C_END  = 5'd15;
  localparam logic [4:0] S_P_INIT = 5'd16;
  localparam logic [4:0] S_P_RD   = 5'd17;
  localparam logic [4:0] S_P_EV   = 5'd18;
  localparam logic [4:0] S_Q_INIT = 5'd19;
  localparam logic [4:0] S_Q_RD   = 5'd20;
  localparam logic [4:0] S_Q_EV   = 5'd21;
  localparam logic [4:0] S_Q_END  = 5'd22;
  localparam logic [4:0] S_M_INIT = 5'd23;
  localparam logic [4:0] S_M_RD   = 5'd24;
  localparam logic [4:0] S_M_EV   = 5'd25;
  localparam logic [4:0] S_FIN    = 5'd26;

  logic [4:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and micro-op
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH;
          unique case (in_command)
            CMD_CLEAR:    state_nxt = S_CLR;
            CMD_APPEND:   state_nxt = S_APP;
            CMD_ALLOCATE: state_nxt = S_A_INIT;
            CMD_COALESCE: state_nxt = S_C_INIT;
            CMD_COMPACT:  state_nxt = S_P_INIT;
            CMD_READ:     state_nxt = S_RDI;
            default:      state_nxt = S_M_INIT;
          endcase
        end
      end
      S_CLR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_M_INIT;
      end
      S_APP: begin
        cmd.op    = OP_APPEND;
        state_nxt = S_M_INIT;
      end
      S_RDI: begin
        cmd.op    = OP_RD_ISSUE;
        state_nxt = stat.in_range ? S_RDT : S_M_INIT;
      end
      S_RDT: begin
        cmd.op    = OP_RD_TAKE;
        state_nxt = S_M_INIT;
      end
      // allocate: hole search
      S_A_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_A_RD;
      end
      S_A_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_A_DEC;
        end else begin
          cmd.op    = OP_READ_I;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd.op    = OP_A_EVAL;
        state_nxt = S_A_RD;
      end
      S_A_DEC: begin
        cmd.op    = OP_A_DEC;
        state_nxt = (!stat.dec_fail && stat.dec_split) ? S_S_RD : S_M_INIT;
      end
      // allocate: open a slot for the remainder
      S_S_RD: begin
        if (stat.shift_end) begin
          state_nxt = S_S_INS;
        end else begin
          cmd.op    = OP_S_READ;
          state_nxt = S_S_WR;
        end
      end
      S_S_WR: begin
        cmd.op    = OP_S_WRITE;
        state_nxt = S_S_RD;
      end
      S_S_INS: begin
        cmd.op    = OP_S_INS;
        state_nxt = S_M_INIT;
      end
      // coalesce
      S_C_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_C_RD;
      end
      S_C_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_C_END;
        end else begin
          cmd.op    = OP_READ_I;
          state_nxt = S_C_EV;
        end
      end
      S_C_EV: begin
        cmd.op    = OP_C_EVAL;
        state_nxt = S_C_RD;
      end
      S_C_END: begin
        cmd.op    = OP_C_END;
        state_nxt = S_M_INIT;
      end
      // compact: total and last free entry
      S_P_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        if (stat.scan_end) begin
          state_nxt = stat.any_free ? S_Q_INIT : S_M_INIT;
        end else begin
          cmd.op    = OP_READ_I;
          state_nxt = S_P_EV;
        end
      end
      S_P_EV: begin
        cmd.op    = OP_P_EVAL;
        state_nxt = S_P_RD;
      end
      // compact: rewrite
      S_Q_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_Q_RD;
      end
      S_Q_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_Q_END;
        end else begin
          cmd.op    = OP_READ_I;
          state_nxt = S_Q_EV;
        end
      end
      S_Q_EV: begin
        cmd.op    = OP_Q_EVAL;
        state_nxt = S_Q_RD;
      end
      S_Q_END: begin
        cmd.op    = OP_Q_END;
        state_nxt = S_M_INIT;
      end
      // free total over the final table
      S_M_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_M_RD;
      end
      S_M_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_READ_I;
          state_nxt = S_M_EV;
        end
      end
      S_M_EV: begin
        cmd.op    = OP_M_EVAL;
        state_nxt = S_M_RD;
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/vpa_dp.sv @@
// Partition table memory, scan registers, accumulators and result register.
`default_nettype none

module vpa_dp
  import vpa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_AW-1:0]    cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_wdata,
  input  wire logic [PID_W-1:0]     in_process_id,
  input  wire logic                 in_entry_is_free,
  input  wire logic [SIZE_BITS-1:0] in_request_size,
  input  wire logic [IDX_W-1:0]     in_read_index,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ST_W-1:0]           out_status,
  output logic [IDX_W-1:0]          out_position,
  output logic                      out_slot_free,
  output logic [PID_W-1:0]          out_slot_owner,
  output logic [SIZE_BITS-1:0]      out_slot_size,
  output logic [CNT_OUT_W-1:0]      out_entry_count,
  output logic [FT_W-1:0]           out_free_total
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int PW = (IW > IDX_W) ? IW : IDX_W;
  localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SLOTS);

  function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                   input logic [SIZE_BITS-1:0] b);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_BITS] ? SIZE_MAX : s[SIZE_BITS-1:0];
  endfunction

  // Table memory
  logic                 mem_free  [0:MAX_SLOTS-1];
  logic [PID_W-1:0]     mem_owner [0:MAX_SLOTS-1];
  logic [SIZE_BITS-1:0] mem_size  [0:MAX_SLOTS-1];

  logic                 we, re;
  logic [IW-1:0]        waddr, raddr;
  logic                 wfree;
  logic [PID_W-1:0]     wowner;
  logic [SIZE_BITS-1:0] wsize;
  logic                 rd_free_r;
  logic [PID_W-1:0]     rd_owner_r;
  logic [SIZE_BITS-1:0] rd_size_r;

  // Control state
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     nfp_r, nfp_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CFG_DW-1:0] sp_r, sp_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers
  logic [CW-1:0]        i_r, i_nxt, w_r, w_nxt;
  logic [PID_W-1:0]     pid_r, pid_nxt;
  logic                 isf_r, isf_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [IDX_W-1:0]     ridx_r, ridx_nxt;
  logic                 fa_v_r, fa_v_nxt, fn_v_r, fn_v_nxt, bc_v_r, bc_v_nxt;
  logic [IW-1:0]        fa_idx_r, fa_idx_nxt, fn_idx_r, fn_idx_nxt, bc_idx_r, bc_idx_nxt;
  logic [SIZE_BITS-1:0] fa_size_r, fa_size_nxt, fn_size_r, fn_size_nxt;
  logic [SIZE_BITS-1:0] bc_size_r, bc_size_nxt, bc_rem_r, bc_rem_nxt;
  logic [IW-1:0]        hidx_r, hidx_nxt;
  logic [SIZE_BITS-1:0] hrem_r, hrem_nxt;
  logic                 pend_v_r, pend_v_nxt, pend_free_r, pend_free_nxt;
  logic [PID_W-1:0]     pend_owner_r, pend_owner_nxt;
  logic [SIZE_BITS-1:0] pend_size_r, pend_size_nxt;
  logic [SIZE_BITS-1:0] total_r, total_nxt;
  logic [IW-1:0]        last_r, last_nxt;
  logic                 any_r, any_nxt;
  logic [FT_W-1:0]      ftot_r, ftot_nxt;
  logic [ST_W-1:0]      st_r, st_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic                 rf_r, rf_nxt;
  logic [PID_W-1:0]     ro_r, ro_nxt;
  logic [SIZE_BITS-1:0] rs_r, rs_nxt;

  // Result register
  logic [ST_W-1:0]      o_st_r, o_st_nxt;
  logic [IDX_W-1:0]     o_pos_r, o_pos_nxt;
  logic                 o_rf_r, o_rf_nxt;
  logic [PID_W-1:0]     o_ro_r, o_ro_nxt;
  logic [SIZE_BITS-1:0] o_rs_r, o_rs_nxt;
  logic [CNT_OUT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic [FT_W-1:0]      o_ft_r, o_ft_nxt;

  // Scan helpers
  logic [IW-1:0]        cur_idx;
  logic                 fits, after_ptr, full, merge, better;
  logic [SIZE_BITS-1:0] cur_rem;
  logic                 sel_v;
  logic [IW-1:0]        sel_idx;
  logic [SIZE_BITS-1:0] sel_size, sel_rem;

  assign cur_idx   = i_r[IW-1:0];
  assign fits      = rd_free_r && (rd_size_r >= req_r);
  assign cur_rem   = rd_size_r - req_r;
  assign after_ptr = XW'(i_r) > XW'(nfp_r);
  assign full      = (cnt_r >= FULL_CNT);
  assign merge     = pend_v_r && pend_free_r && rd_free_r;
  assign better    = (mode_r == FIT_BEST) ? (cur_rem <= bc_rem_r) : (cur_rem >= bc_rem_r);

  // Hole chosen by the placement policy
  always_comb begin
    case (mode_r) inside
      FIT_FIRST: begin
        sel_v = fa_v_r; sel_idx = fa_idx_r; sel_size = fa_size_r;
      end
      FIT_BEST, FIT_WORST: begin
        sel_v = bc_v_r; sel_idx = bc_idx_r; sel_size = bc_size_r;
      end
      default: begin
        if (fn_v_r) begin
          sel_v = 1'b1; sel_idx = fn_idx_r; sel_size = fn_size_r;
        end else begin
          sel_v = fa_v_r; sel_idx = fa_idx_r; sel_size = fa_size_r;
        end
      end
    endcase
  end
  assign sel_rem = sel_size - req_r;

  assign stat.scan_end  = (i_r >= cnt_r);
  assign stat.shift_end = (i_r <= (CW'(hidx_r) + 1'b1));
  assign stat.in_range  = (XW'(ridx_r) < XW'(cnt_r));
  assign stat.dec_fail  = !sel_v || ((sel_rem != '0) && full);
  assign stat.dec_split = sel_v && (sel_rem != '0) && !full;
  assign stat.any_free  = any_r;
  assign stat.out_full  = out_valid_r && out_stall;

  // Memory port selection
  always_comb begin
    we     = 1'b0;
    waddr  = '0;
    wfree  = 1'b0;
    wowner = '0;
    wsize  = '0;
    re     = 1'b0;
    raddr  = '0;
    unique case (cmd.op)
      OP_APPEND: begin
        we = !full; waddr = cnt_r[IW-1:0];
        wfree = isf_r; wowner = pid_r; wsize = req_r;
      end
      OP_RD_ISSUE: begin
        re = stat.in_range; raddr = IW'(ridx_r);
      end
      OP_READ_I: begin
        re = 1'b1; raddr = cur_idx;
      end
      OP_A_DEC: begin
        we = !stat.dec_fail; waddr = sel_idx;
        wfree = 1'b0; wowner = pid_r; wsize = req_r;
      end
      OP_S_READ: begin
        re = 1'b1; raddr = cur_idx - 1'b1;
      end
      OP_S_WRITE: begin
        we = 1'b1; waddr = cur_idx;
        wfree = rd_free_r; wowner = rd_owner_r; wsize = rd_size_r;
      end
      OP_S_INS: begin
        we = 1'b1; waddr = hidx_r + 1'b1;
        wfree = 1'b1; wowner = OWNER_FREE; wsize = hrem_r;
      end
      OP_C_EVAL: begin
        we = pend_v_r && !merge; waddr = w_r[IW-1:0];
        wfree = pend_free_r; wowner = pend_owner_r; wsize = pend_size_r;
      end
      OP_C_END: begin
        we = pend_v_r; waddr = w_r[IW-1:0];
        wfree = pend_free_r; wowner = pend_owner_r; wsize = pend_size_r;
      end
      OP_Q_EVAL: begin
        waddr = w_r[IW-1:0];
        if (!rd_free_r) begin
          we = 1'b1; wfree = 1'b0; wowner = rd_owner_r; wsize = rd_size_r;
        end else if (cur_idx == last_r) begin
          we = 1'b1; wfree = 1'b1; wowner = OWNER_FREE; wsize = total_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_free[waddr]  <= wfree;
      mem_owner[waddr] <= wowner;
      mem_size[waddr]  <= wsize;
    end
    if (re) begin
      rd_free_r  <= mem_free[raddr];
      rd_owner_r <= mem_owner[raddr];
      rd_size_r  <= mem_size[raddr];
    end
  end

  // Next values
  always_comb begin
    cnt_nxt = cnt_r; nfp_nxt = nfp_r; mode_nxt = mode_r; sp_nxt = sp_r;
    out_valid_nxt = out_valid_r;
    i_nxt = i_r; w_nxt = w_r;
    pid_nxt = pid_r; isf_nxt = isf_r; req_nxt = req_r; ridx_nxt = ridx_r;
    fa_v_nxt = fa_v_r; fa_idx_nxt = fa_idx_r; fa_size_nxt = fa_size_r;
    fn_v_nxt = fn_v_r; fn_idx_nxt = fn_idx_r; fn_size_nxt = fn_size_r;
    bc_v_nxt = bc_v_r; bc_idx_nxt = bc_idx_r; bc_size_nxt = bc_size_r;
    bc_rem_nxt = bc_rem_r;
    hidx_nxt = hidx_r; hrem_nxt = hrem_r;
    pend_v_nxt = pend_v_r; pend_free_nxt = pend_free_r;
    pend_owner_nxt = pend_owner_r; pend_size_nxt = pend_size_r;
    total_nxt = total_r; last_nxt = last_r; any_nxt = any_r; ftot_nxt = ftot_r;
    st_nxt = st_r; pos_nxt = pos_r; rf_nxt = rf_r; ro_nxt = ro_r; rs_nxt = rs_r;
    o_st_nxt = o_st_r; o_pos_nxt = o_pos_r; o_rf_nxt = o_rf_r; o_ro_nxt = o_ro_r;
    o_rs_nxt = o_rs_r; o_cnt_nxt = o_cnt_r; o_ft_nxt = o_ft_r;

    // configuration writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIT_MODE:  mode_nxt = cfg_wdata[MODE_W-1:0];
        REG_START_PTR: sp_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // result taken downstream
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (cmd.op)
      OP_LATCH: begin
        pid_nxt = in_process_id; isf_nxt = in_entry_is_free;
        req_nxt = in_request_size; ridx_nxt = in_read_index;
        st_nxt = ST_OK; pos_nxt = '0; rf_nxt = 1'b0; ro_nxt = '0; rs_nxt = '0;
        fa_v_nxt = 1'b0; fn_v_nxt = 1'b0; bc_v_nxt = 1'b0;
        total_nxt = '0; any_nxt = 1'b0; ftot_nxt = '0;
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
        nfp_nxt = PW'(sp_r);
      end
      OP_APPEND: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          pos_nxt = IDX_W'(cnt_r);
        end
      end
      OP_RD_ISSUE: begin
        pos_nxt = ridx_r;
        if (!stat.in_range) st_nxt = ST_FULL;
      end
      OP_RD_TAKE: begin
        rf_nxt = rd_free_r;
        ro_nxt = rd_free_r ? '0 : rd_owner_r;
        rs_nxt = rd_size_r;
      end
      OP_SCAN_INIT: begin
        i_nxt = '0; w_nxt = '0; pend_v_nxt = 1'b0;
      end
      OP_A_EVAL: begin
        if (fits) begin
          if (!fa_v_r) begin
            fa_v_nxt = 1'b1; fa_idx_nxt = cur_idx; fa_size_nxt = rd_size_r;
          end
          if (!fn_v_r && after_ptr) begin
            fn_v_nxt = 1'b1; fn_idx_nxt = cur_idx; fn_size_nxt = rd_size_r;
          end
          // ties go to the later entry
          if (!bc_v_r || better) begin
            bc_v_nxt = 1'b1; bc_idx_nxt = cur_idx; bc_size_nxt = rd_size_r;
            bc_rem_nxt = cur_rem;
          end
        end
        i_nxt = i_r + 1'b1;
      end
      OP_A_DEC: begin
        if (!sel_v) begin
          st_nxt = ST_NOFIT;
        end else if ((sel_rem != '0) && full) begin
          st_nxt = ST_FULL;
        end else begin
          if (mode_r == FIT_NEXT) nfp_nxt = PW'(sel_idx);
          pos_nxt = IDX_W'(sel_idx);
          hidx_nxt = sel_idx;
          hrem_nxt = sel_rem;
          i_nxt = cnt_r;
        end
      end
      OP_S_WRITE: i_nxt = i_r - 1'b1;
      OP_S_INS:   cnt_nxt = cnt_r + 1'b1;
      OP_C_EVAL: begin
        if (merge) begin
          pend_size_nxt = sat_add(pend_size_r, rd_size_r);
        end else begin
          if (pend_v_r) w_nxt = w_r + 1'b1;
          pend_v_nxt = 1'b1; pend_free_nxt = rd_free_r;
          pend_owner_nxt = rd_owner_r; pend_size_nxt = rd_size_r;
        end
        i_nxt = i_r + 1'b1;
      end
      OP_C_END: cnt_nxt = w_r + CW'(pend_v_r);
      OP_P_EVAL: begin
        if (rd_free_r) begin
          total_nxt = sat_add(total_r, rd_size_r);
          last_nxt = cur_idx;
          any_nxt = 1'b1;
        end
        i_nxt = i_r + 1'b1;
      end
      OP_Q_EVAL: begin
        if (!rd_free_r || (cur_idx == last_r)) w_nxt = w_r + 1'b1;
        i_nxt = i_r + 1'b1;
      end
      OP_Q_END: cnt_nxt = w_r;
      OP_M_EVAL: begin
        if (rd_free_r) ftot_nxt = ftot_r + FT_W'(rd_size_r);
        i_nxt = i_r + 1'b1;
      end
      OP_FIN: begin
        o_st_nxt = st_r; o_pos_nxt = pos_r; o_rf_nxt = rf_r; o_ro_nxt = ro_r;
        o_rs_nxt = rs_r; o_cnt_nxt = CNT_OUT_W'(cnt_r); o_ft_nxt = ftot_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nfp_r       <= '0;
      mode_r      <= FIT_FIRST;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      nfp_r       <= nfp_nxt;
      mode_r      <= mode_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt; w_r <= w_nxt;
    pid_r <= pid_nxt; isf_r <= isf_nxt; req_r <= req_nxt; ridx_r <= ridx_nxt;
    fa_v_r <= fa_v_nxt; fa_idx_r <= fa_idx_nxt; fa_size_r <= fa_size_nxt;
    fn_v_r <= fn_v_nxt; fn_idx_r <= fn_idx_nxt; fn_size_r <= fn_size_nxt;
    bc_v_r <= bc_v_nxt; bc_idx_r <= bc_idx_nxt; bc_size_r <= bc_size_nxt;
    bc_rem_r <= bc_rem_nxt;
    hidx_r <= hidx_nxt; hrem_r <= hrem_nxt;
    pend_v_r <= pend_v_nxt; pend_free_r <= pend_free_nxt;
    pend_owner_r <= pend_owner_nxt; pend_size_r <= pend_size_nxt;
    total_r <= total_nxt; last_r <= last_nxt; any_r <= any_nxt; ftot_r <= ftot_nxt;
    st_r <= st_nxt; pos_r <= pos_nxt; rf_r <= rf_nxt; ro_r <= ro_nxt; rs_r <= rs_nxt;
    o_st_r <= o_st_nxt; o_pos_r <= o_pos_nxt; o_rf_r <= o_rf_nxt; o_ro_r <= o_ro_nxt;
    o_rs_r <= o_rs_nxt; o_cnt_r <= o_cnt_nxt; o_ft_r <= o_ft_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_st_r;
  assign out_position    = o_pos_r;
  assign out_slot_free   = o_rf_r;
  assign out_slot_owner  = o_ro_r;
  assign out_slot_size   = o_rs_r;
  assign out_entry_count = o_cnt_r;
  assign out_free_total  = o_ft_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("entry count beyond table depth");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CW'(waddr) <= cnt_r)) else $error("table write past the end");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_APPEND && !full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("append did not grow the table");

  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_S_INS) |-> !full) else $error("split into a full table");
`endif

endmodule

`default_nettype wire

@@ sv/variable_partition_allocator.sv @@
// Top level of the variable partition allocator: sequencer plus table datapath.
`default_nettype none

// Keeps an ordered table of up to MAX_SLOTS partitions in a single-port-read,
// single-port-write memory with registered read data, and executes one command
// per transaction: clear, append, allocate (first/best/worst/next fit), coalesce,
// compact or read. Every command ends with a pass over the table that sums the
// free sizes, so the memory read port sets the pace: each entry visited takes
// a read state and an evaluate state. Allocate runs a search, a shift to open
// the remainder slot, then the free sum. A new transaction is accepted as soon
// as the previous result sits in the output register, even while that result is
// still stalled. Configuration is written through a plain write port; the fit
// mode is used by every later allocate decision and the start pointer is loaded
// into the next-fit pointer by the next clear.
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_AW-1:0]    cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [PID_W-1:0]     in_process_id,
  input  wire logic                 in_entry_is_free,
  input  wire logic [SIZE_BITS-1:0] in_request_size,
  input  wire logic [IDX_W-1:0]     in_read_index,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ST_W-1:0]           out_status,
  output logic [IDX_W-1:0]          out_position,
  output logic                      out_slot_free,
  output logic [PID_W-1:0]          out_slot_owner,
  output logic [SIZE_BITS-1:0]      out_slot_size,
  output logic [CNT_OUT_W-1:0]      out_entry_count,
  output logic [FT_W-1:0]           out_free_total
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .cmd        (cmd),
    .stat       (stat)
  );

  vpa_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_process_id    (in_process_id),
    .in_entry_is_free (in_entry_is_free),
    .in_request_size  (in_request_size),
    .in_read_index    (in_read_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_position     (out_position),
    .out_slot_free    (out_slot_free),
    .out_slot_owner   (out_slot_owner),
    .out_slot_size    (out_slot_size),
    .out_entry_count  (out_entry_count),
    .out_free_total   (out_free_total)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the variable partition allocator.
`timescale 1ns / 100ps

module tb_top;
  import vpa_pkg::*;

  localparam int SLOTS    = MAX_SLOTS_DEF;
  localparam int SZ_W     = SIZE_BITS_DEF;
  localparam int SIZE_TOP = (1 << SZ_W) - 1;
  localparam int LONG_HOLD = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  typedef struct {
    logic [ST_W-1:0]      status;
    logic [IDX_W-1:0]     position;
    logic                 slot_free;
    logic [PID_W-1:0]     owner;
    logic [SZ_W-1:0]      size;
    logic [CNT_OUT_W-1:0] count;
    logic [FT_W-1:0]      free_sum;
  } alloc_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_command;
  logic [PID_W-1:0] in_process_id;
  logic in_entry_is_free;
  logic [SZ_W-1:0] in_request_size;
  logic [IDX_W-1:0] in_read_index;
  logic out_valid;
  logic out_stall;
  logic [ST_W-1:0] out_status;
  logic [IDX_W-1:0] out_position;
  logic out_slot_free;
  logic [PID_W-1:0] out_slot_owner;
  logic [SZ_W-1:0] out_slot_size;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic [FT_W-1:0] out_free_total;

  // shadow partition table
  logic [PID_W-1:0] part_owner[SLOTS];
  logic             part_free[SLOTS];
  logic [SZ_W-1:0]  part_size[SLOTS];
  int               part_count;
  int               nf_ptr;
  logic [MODE_W-1:0] sh_mode;
  logic [IDX_W-1:0]  sh_start;

  alloc_result_t pending_results[$];
  int  errors;
  bit  idle_on;
  bit  hold_req;
  int  hold_cnt;
  int  stall_left;

  variable_partition_allocator dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("** variable_partition_allocator: FAILED **");
    $finish;
  end

  // receiver stall: random bursts, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      stall_left <= 0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [SZ_W-1:0] sat_sum(logic [SZ_W-1:0] a, logic [SZ_W-1:0] b);
    logic [SZ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SZ_W] ? SZ_W'(SIZE_TOP) : s[SZ_W-1:0];
  endfunction

  function automatic bool_fits(int i, logic [SZ_W-1:0] req);
    return part_free[i] && part_size[i] >= req;
  endfunction

  // hole search under the current placement policy; -1 when nothing fits
  function automatic int locate_hole(logic [SZ_W-1:0] req);
    int found;
    int idx;
    logic [SZ_W-1:0] rem;
    logic [SZ_W-1:0] best;
    found = -1;
    best = '0;
    if (sh_mode == FIT_FIRST) begin
      for (int i = 0; i < part_count; i++)
        if (bool_fits(i, req)) return i;
    end else if (sh_mode == FIT_BEST || sh_mode == FIT_WORST) begin
      for (int i = 0; i < part_count; i++) begin
        if (bool_fits(i, req)) begin
          rem = part_size[i] - req;
          if (found < 0 || (sh_mode == FIT_BEST ? rem <= best : rem >= best)) begin
            found = i;
            best = rem;
          end
        end
      end
    end else begin
      for (int k = 0; k < part_count; k++) begin
        idx = (nf_ptr >= part_count) ? k : (nf_ptr + 1 + k) % part_count;
        if (bool_fits(idx, req)) return idx;
      end
    end
    return found;
  endfunction

  task automatic open_slot(int pos, logic [PID_W-1:0] own, logic fr, logic [SZ_W-1:0] sz);
    for (int i = part_count; i > pos; i--) begin
      part_owner[i] = part_owner[i-1];
      part_free[i] = part_free[i-1];
      part_size[i] = part_size[i-1];
    end
    part_owner[pos] = own;
    part_free[pos] = fr;
    part_size[pos] = sz;
    part_count++;
  endtask

  // update the shadow table for one accepted command and queue its result
  task automatic predict_command(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid, logic isf,
                                 logic [SZ_W-1:0] req, logic [IDX_W-1:0] ridx);
    alloc_result_t r;
    int h;
    int n;
    int last;
    logic [SZ_W-1:0] rem;
    logic [SZ_W-1:0] total;
    logic [FT_W-1:0] fsum;
    r = '{default: '0};
    case (cmd)
      CMD_CLEAR: begin
        part_count = 0;
        nf_ptr = int'(sh_start);
      end
      CMD_APPEND: begin
        if (part_count >= SLOTS) r.status = ST_FULL;
        else begin
          r.position = IDX_W'(part_count);
          open_slot(part_count, pid, isf, req);
        end
      end
      CMD_ALLOCATE: begin
        h = locate_hole(req);
        if (h < 0) r.status = ST_NOFIT;
        else begin
          rem = part_size[h] - req;
          if (rem != 0 && part_count >= SLOTS) r.status = ST_FULL;
          else begin
            part_owner[h] = pid;
            part_free[h] = 1'b0;
            part_size[h] = req;
            if (rem != 0) open_slot(h + 1, OWNER_FREE, 1'b1, rem);
            if (sh_mode == FIT_NEXT) nf_ptr = h;
            r.position = IDX_W'(h);
          end
        end
      end
      CMD_COALESCE: begin
        n = 0;
        while (n + 1 < part_count) begin
          if (part_free[n] && part_free[n+1]) begin
            part_size[n] = sat_sum(part_size[n], part_size[n+1]);
            for (int i = n + 1; i + 1 < part_count; i++) begin
              part_owner[i] = part_owner[i+1];
              part_free[i] = part_free[i+1];
              part_size[i] = part_size[i+1];
            end
            part_count--;
          end else n++;
        end
      end
      CMD_COMPACT: begin
        total = '0;
        last = -1;
        for (int i = 0; i < part_count; i++)
          if (part_free[i]) begin
            total = sat_sum(total, part_size[i]);
            last = i;
          end
        if (last >= 0) begin
          n = 0;
          for (int i = 0; i < part_count; i++) begin
            if (!part_free[i]) begin
              part_owner[n] = part_owner[i];
              part_free[n] = 1'b0;
              part_size[n] = part_size[i];
              n++;
            end else if (i == last) begin
              part_owner[n] = OWNER_FREE;
              part_free[n] = 1'b1;
              part_size[n] = total;
              n++;
            end
          end
          part_count = n;
        end
      end
      CMD_READ: begin
        r.position = ridx;
        if (ridx >= part_count) r.status = ST_FULL;
        else begin
          r.slot_free = part_free[ridx];
          r.owner = part_free[ridx] ? '0 : part_owner[ridx];
          r.size = part_size[ridx];
        end
      end
      default: ;
    endcase
    fsum = '0;
    for (int i = 0; i < part_count; i++)
      if (part_free[i]) fsum = fsum + FT_W'(part_size[i]);
    r.count = CNT_OUT_W'(part_count);
    r.free_sum = fsum;
    pending_results.push_back(r);
  endtask

  // offer one transaction, wait for acceptance, then predict it
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid, logic isf,
                          logic [SZ_W-1:0] req, logic [IDX_W-1:0] ridx);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_process_id <= pid;
    in_entry_is_free <= isf;
    in_request_size <= req;
    in_read_index <= ridx;
    do begin
      @(negedge clk);
      taken = in_valid && !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_command(cmd, pid, isf, req, ridx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FIT_MODE) sh_mode = val[MODE_W-1:0];
    else sh_start = val[IDX_W-1:0];
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checker: a transaction completes at the next rising edge
  always @(negedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d position %0d", $time, out_status,
                 out_position);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("position", e.position, out_position);
        check_field("slot_free", e.slot_free, out_slot_free);
        check_field("slot_owner", e.owner, out_slot_owner);
        check_field("slot_size", e.size, out_slot_size);
        check_field("entry_count", e.count, out_entry_count);
        check_field("free_total", e.free_sum, out_free_total);
      end
    end
  end

  // extremes, every command and the named corner cases
  task automatic test_directed();
    send_cmd(CMD_ALLOCATE, 16'h1234, 1'b0, 24'd5, '0);          // empty table
    send_cmd(CMD_APPEND, 16'h0000, 1'b0, 24'd0, '0);
    send_cmd(CMD_APPEND, 16'hFFFF, 1'b1, 24'hFFFFFF, '0);
    send_cmd(CMD_APPEND, 16'hA5A5, 1'b1, 24'hFFFFFF, '0);
    send_cmd(CMD_APPEND, 16'h5A5A, 1'b1, 24'd100, '0);
    send_cmd(CMD_READ, '0, 1'b0, '0, 6'd0);
    send_cmd(CMD_READ, '0, 1'b0, '0, 6'd1);
    send_cmd(CMD_READ, '0, 1'b0, '0, 6'd63);                   // out of range
    send_cmd(CMD_ALLOCATE, 16'hBEEF, 1'b0, 24'hFFFFFF, '0);     // exact fit
    send_cmd(CMD_ALLOCATE, 16'h0001, 1'b0, 24'd40, '0);         // split
    send_cmd(CMD_ALLOCATE, 16'h0002, 1'b0, 24'hFFFFFF, '0);     // no fit
    send_cmd(CMD_COALESCE, '0, 1'b0, '0, '0);
    send_cmd(CMD_APPEND, 16'h0003, 1'b1, 24'hFFFFF0, '0);
    send_cmd(CMD_APPEND, 16'h0004, 1'b1, 24'hFFFFF0, '0);
    send_cmd(CMD_COALESCE, '0, 1'b0, '0, '0);                   // saturates
    send_cmd(CMD_APPEND, 16'h0005, 1'b0, 24'd7, '0);
    send_cmd(CMD_APPEND, 16'h0006, 1'b1, 24'hFFFFFF, '0);
    send_cmd(CMD_COMPACT, '0, 1'b0, '0, '0);                    // saturates
    send_cmd(CMD_READ, '0, 1'b0, '0, 6'd2);
    send_cmd(CMD_UNUSED_A, 16'hFFFF, 1'b1, 24'hFFFFFF, 6'd63);
    send_cmd(CMD_UNUSED_B, 16'h0, 1'b0, 24'd0, 6'd0);
    send_cmd(CMD_CLEAR, '0, 1'b0, '0, '0);
    send_cmd(CMD_APPEND, 16'h0007, 1'b0, 24'd9, '0);
    send_cmd(CMD_COMPACT, '0, 1'b0, '0, '0);                    // nothing free
  endtask

  // full table: append and split both refused
  task automatic test_table_full();
    send_cmd(CMD_CLEAR, '0, 1'b0, '0, '0);
    for (int i = 0; i < SLOTS; i++)
      send_cmd(CMD_APPEND, PID_W'(i), 1'(i % 2), SZ_W'(50 + i), '0);
    send_cmd(CMD_APPEND, 16'h00AA, 1'b0, 24'd1, '0);
    send_cmd(CMD_ALLOCATE, 16'h00BB, 1'b0, 24'd10, '0);
    send_cmd(CMD_ALLOCATE, 16'h00CC, 1'b0, 24'd51, '0);         // exact, no split
    send_cmd(CMD_READ, '0, 1'b0, '0, 6'd63);
  endtask

  // well-formed random traffic: mostly build-up, allocate and read
  task automatic test_random_traffic(int items);
    int pick;
    logic [SZ_W-1:0] sz;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      sz = ($urandom_range(0, 5) == 0) ? SZ_W'($urandom) : SZ_W'($urandom_range(0, 64));
      if (pick < 3 || (part_count > 48 && pick < 12))
        send_cmd(CMD_CLEAR, PID_W'($urandom), 1'($urandom), SZ_W'($urandom), IDX_W'($urandom));
      else if (pick < 35)
        send_cmd(CMD_APPEND, PID_W'($urandom), 1'($urandom_range(0, 2) != 0), sz, '0);
      else if (pick < 65)
        send_cmd(CMD_ALLOCATE, PID_W'($urandom), 1'($urandom),
                 ($urandom_range(0, 7) == 0) ? SZ_W'($urandom) : SZ_W'($urandom_range(0, 40)),
                 IDX_W'($urandom));
      else if (pick < 85)
        send_cmd(CMD_READ, PID_W'($urandom), 1'($urandom), SZ_W'($urandom),
                 IDX_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, part_count)));
      else if (pick < 91)
        send_cmd(CMD_COALESCE, PID_W'($urandom), 1'($urandom), SZ_W'($urandom), '0);
      else if (pick < 97)
        send_cmd(CMD_COMPACT, PID_W'($urandom), 1'($urandom), SZ_W'($urandom), '0);
      else
        send_cmd(($urandom_range(0, 1) != 0) ? CMD_UNUSED_A : CMD_UNUSED_B, PID_W'($urandom),
                 1'($urandom), SZ_W'($urandom), IDX_W'($urandom));
    end
  endtask

  // each placement policy with several start pointers
  task automatic test_fit_modes();
    logic [IDX_W-1:0] starts[3];
    starts[0] = '0;
    starts[1] = 6'd63;
    starts[2] = IDX_W'($urandom_range(1, 20));
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_FIT_MODE, CFG_DW'(m));
      write_reg(REG_START_PTR, CFG_DW'(starts[m % 3]));
      send_cmd(CMD_CLEAR, '0, 1'b0, '0, '0);
      test_random_traffic(150);
      if (m == FIT_NEXT) begin
        write_reg(REG_START_PTR, CFG_DW'(starts[2]));
        send_cmd(CMD_CLEAR, '0, 1'b0, '0, '0);
        test_random_traffic(150);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_back_pressure();
    write_reg(REG_FIT_MODE, CFG_DW'(FIT_BEST));
    hold_req <= 1'b1;
    test_random_traffic(30);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = CMD_CLEAR;
    in_process_id = '0;
    in_entry_is_free = 1'b0;
    in_request_size = '0;
    in_read_index = '0;
    hold_req = 1'b0;
    errors = 0;
    idle_on = 1'b1;
    part_count = 0;
    nf_ptr = 0;
    sh_mode = FIT_FIRST;
    sh_start = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_fit_modes();
    test_back_pressure();
    write_reg(REG_FIT_MODE, CFG_DW'(FIT_WORST));
    test_random_traffic(350);
    idle_on = 1'b0;
    write_reg(REG_FIT_MODE, CFG_DW'(FIT_NEXT));
    test_random_traffic(200);

    drain_results();
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("** variable_partition_allocator: PASSED **");
    else
      $display("** variable_partition_allocator: FAILED **");
    $finish;
  end

endmodule
